### src/utf8d_pkg.sv
// types and constants shared by the utf-8 to utf-16 decoder modules
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int unsigned ACC_W  = 21;
    localparam int unsigned UNIT_W = 16;

    localparam logic [ACC_W-1:0]  SUPP_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR   = 16'hd800;
    localparam logic [UNIT_W-1:0] LO_SURR   = 16'hdc00;
    localparam logic [1:0]        CONT_TAG  = 2'b10;

    // results caused by one request, at most a surrogate pair
    typedef struct packed {
        logic              has0;
        logic              has1;
        logic [UNIT_W-1:0] unit0;
        logic              err0;
        logic              last0;
        logic [UNIT_W-1:0] unit1;
    } t_dec_res;

    // one queued result
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              err;
        logic              last;
    } t_unit_slot;

endpackage

### src/utf8d_decode.sv
// sequence tracking and code point to utf-16 conversion for one byte
`timescale 1ns / 1ps

module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte_in,
    input  logic       i_drop_partial,
    output t_dec_res   o_res
);

    logic [ACC_W-1:0] r_code_accum, n_code_accum;
    logic [1:0]       r_bytes_pending, n_bytes_pending;

    logic [ACC_W-1:0] acc;
    logic [1:0]       pend;
    logic [ACC_W-1:0] cont_acc;
    logic [ACC_W-1:0] cp;
    logic             done;
    logic [ACC_W-1:0] supp;

    always_comb begin
        acc  = i_drop_partial ? '0 : r_code_accum;
        pend = i_drop_partial ? 2'd0 : r_bytes_pending;
        cont_acc = {acc[ACC_W-7:0], i_byte_in[5:0]};

        n_code_accum    = acc;
        n_bytes_pending = pend;
        done  = 1'b0;
        cp    = cont_acc;
        o_res = '0;

        if (pend != 2'd0) begin
            if (i_byte_in[7:6] != CONT_TAG) begin
                n_code_accum    = '0;
                n_bytes_pending = 2'd0;
                o_res.has0  = 1'b1;
                o_res.err0  = 1'b1;
                o_res.last0 = 1'b1;
            end else begin
                n_code_accum    = cont_acc;
                n_bytes_pending = pend - 2'd1;
                done = (pend == 2'd1);
                cp   = cont_acc;
            end
        end else begin
            unique casez (i_byte_in)
                8'b0???????: begin
                    n_code_accum = {{(ACC_W-8){1'b0}}, i_byte_in};
                    cp   = {{(ACC_W-8){1'b0}}, i_byte_in};
                    done = 1'b1;
                end
                8'b110?????: begin
                    n_code_accum    = {{(ACC_W-5){1'b0}}, i_byte_in[4:0]};
                    n_bytes_pending = 2'd1;
                end
                8'b1110????: begin
                    n_code_accum    = {{(ACC_W-4){1'b0}}, i_byte_in[3:0]};
                    n_bytes_pending = 2'd2;
                end
                8'b11110???: begin
                    n_code_accum    = {{(ACC_W-3){1'b0}}, i_byte_in[2:0]};
                    n_bytes_pending = 2'd3;
                end
                default: begin
                    // stray continuation byte or 11111xxx
                    n_code_accum = '0;
                    o_res.has0  = 1'b1;
                    o_res.err0  = 1'b1;
                    o_res.last0 = 1'b1;
                end
            endcase
        end

        supp = cp - SUPP_BASE;
        if (done) begin
            o_res.has0 = 1'b1;
            if (cp < SUPP_BASE) begin
                o_res.unit0 = cp[UNIT_W-1:0];
                o_res.last0 = 1'b1;
            end else begin
                o_res.has1  = 1'b1;
                o_res.unit0 = HI_SURR | {5'd0, supp[ACC_W-1:10]};
                o_res.unit1 = LO_SURR | {6'd0, supp[9:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_accum    <= '0;
            r_bytes_pending <= 2'd0;
        end else if (i_accept) begin
            r_code_accum    <= n_code_accum;
            r_bytes_pending <= n_bytes_pending;
        end
    end

endmodule

### src/utf8d_outbuf.sv
// three-entry result queue with room for a surrogate pair
`timescale 1ns / 1ps

module utf8d_outbuf
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_dec_res          i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [UNIT_W-1:0] o_unit_out,
    output logic              o_is_error,
    output logic              o_last
);

    logic [1:0]       r_cnt, n_cnt;
    t_unit_slot [2:0] r_q, n_q;

    logic       take;
    logic [1:0] base;
    logic       add0;
    logic       add1;

    assign take    = (r_cnt != 2'd0) && !i_stall;
    // keep room for a whole surrogate pair behind what stays queued
    assign o_ready = !r_cnt[1] || (r_cnt == 2'd2 && take);
    assign add0    = i_accept && i_res.has0;
    assign add1    = i_accept && i_res.has1;

    always_comb begin
        n_q  = r_q;
        base = r_cnt;
        if (take) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            base   = r_cnt - 2'd1;
        end
        for (int k = 0; k < 3; k++) begin
            if (add0 && k == int'(base)) begin
                n_q[k] = '{i_res.unit0, i_res.err0, i_res.last0};
            end
            if (add1 && k == int'(base) + 1) begin
                n_q[k] = '{i_res.unit1, 1'b0, 1'b1};
            end
        end
        n_cnt = base + {1'b0, add0} + {1'b0, add1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    assign o_valid    = (r_cnt != 2'd0);
    assign o_unit_out = r_q[0].unit;
    assign o_is_error = r_q[0].err;
    assign o_last     = r_q[0].last;

    a_accept_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> o_ready)
        else $error("request taken without room for its results");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_q[0].err) |-> (r_q[0].last && r_q[0].unit == '0))
        else $error("malformed error result");

    a_pair_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_q[0].last) |-> (r_cnt >= 2'd2))
        else $error("high surrogate queued without its low surrogate");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_q[0])))
        else $error("stalled result changed");

endmodule

### src/utf8_to_utf16_stream_decoder.sv
// top level of the utf-8 byte stream to utf-16 code unit decoder
//
// input channel: one utf-8 byte per request (i_byte_in), with i_drop_partial
// to abandon a partial sequence first; i_buffer_end is carried for software
// and does not change decoding
// output channel: one utf-16 code unit per request, o_is_error marks a bad
// lead or continuation byte (unit is zero), o_last marks the final unit
// caused by an input byte
// a completing byte shows its first unit in the cycle after it is
// taken when no earlier units are queued; lead and middle bytes give no unit
// throughput: one byte per cycle unless stalled; a four-byte sequence above
// 0xffff gives a surrogate pair, queued in a three-entry result buffer so
// the input takes a byte per cycle while the receiver takes a unit per cycle
// an input byte is taken while the buffer keeps room for a surrogate pair
// after this cycle's unit leaves; a stalled receiver fills the buffer and
// then stalls the input, and a stalled result holds
// reset (synchronous, active low) clears the sequence state and empties the
// result buffer
`timescale 1ns / 1ps

module utf8_to_utf16_stream_decoder
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_byte_in,
    input  logic              i_drop_partial,
    input  logic              i_buffer_end,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [UNIT_W-1:0] o_unit_out,
    output logic              o_is_error,
    output logic              o_last
);

    logic     ready;
    logic     accept;
    t_dec_res res;

    assign o_stall = !ready;
    // buffer_end has no effect on the decode
    assign accept  = i_valid && ready && (i_buffer_end || !i_buffer_end);

    utf8d_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte_in      (i_byte_in),
        .i_drop_partial (i_drop_partial),
        .o_res          (res)
    );

    utf8d_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_res      (res),
        .o_ready    (ready),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_unit_out (o_unit_out),
        .o_is_error (o_is_error),
        .o_last     (o_last)
    );

endmodule

### verif/utf8_to_utf16_stream_decoder_test.sv
// testbench for the utf-8 to utf-16 stream decoder: directed table, random byte streams, unit check
`timescale 1ns / 1ps

module utf8_to_utf16_stream_decoder_test;
    import utf8d_pkg::*;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              err;
        logic              last;
    } t_unit_rec;

    typedef struct packed {
        logic [7:0]        octet;
        logic              drop;
        logic              bend;
        logic              fixed;
        logic [UNIT_W-1:0] unit;
        logic              err;
        logic              last;
    } t_byte_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_byte_in;
    logic              i_drop_partial;
    logic              i_buffer_end;
    logic              o_valid;
    logic              i_stall;
    logic [UNIT_W-1:0] o_unit_out;
    logic              o_is_error;
    logic              o_last;

    utf8_to_utf16_stream_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_in      (i_byte_in),
        .i_drop_partial (i_drop_partial),
        .i_buffer_end   (i_buffer_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_unit_out     (o_unit_out),
        .o_is_error     (o_is_error),
        .o_last         (o_last)
    );

    // octet, drop, buffer end, fixed expectation, unit, err, last
    t_byte_req dir_table [25] = '{
        '{8'h00, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1},  // lowest ascii
        '{8'h7f, 1'b0, 1'b1, 1'b1, 16'h007f, 1'b0, 1'b1},  // highest ascii
        '{8'h80, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1},  // stray continuation
        '{8'hf8, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1},  // five-byte lead
        '{8'hff, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1},
        '{8'hc0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // overlong zero passes
        '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hed, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // encoded surrogate
        '{8'ha0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hf0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // surrogate pair
        '{8'h9f, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h98, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hf7, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // beyond 0x10ffff
        '{8'hbf, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hbf, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'he2, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // bad continuation
        '{8'h41, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1},
        '{8'hf0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},  // partial then drop
        '{8'h90, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b0, 1'b1, 16'h0041, 1'b0, 1'b1},
        '{8'hc3, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},  // buffer end mid sequence
        '{8'ha9, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}
    };

    t_byte_req   byte_reqs[$];
    t_unit_rec   decoded_q[$];
    logic [20:0] dec_acc;
    logic [1:0]  dec_pending;
    int          taken_idx;
    int          fault_count;
    t_unit_rec   mon_got;
    t_unit_rec   mon_want;
    t_unit_rec   mon_u0;
    t_unit_rec   mon_u1;
    t_unit_rec   mon_fix;
    int          mon_n;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // utf-8 decode of one byte: updates the running code point, gives 0..2 units
    function automatic void decode_octet(input logic [7:0] b, input logic drop,
                                         output t_unit_rec u0, output t_unit_rec u1,
                                         output int n);
        logic        done;
        logic [20:0] v;
        done = 1'b0;
        n    = 0;
        u0   = '0;
        u1   = '0;
        if (drop) begin
            dec_pending = '0;
            dec_acc     = '0;
        end
        if (dec_pending != 0) begin
            if (b[7:6] != CONT_TAG) begin
                dec_pending = '0;
                dec_acc     = '0;
                u0 = '{16'h0000, 1'b1, 1'b1};
                n  = 1;
            end else begin
                dec_acc     = {dec_acc[14:0], b[5:0]};
                dec_pending = dec_pending - 2'd1;
                done        = (dec_pending == 0);
            end
        end else if (b[7] == 1'b0) begin
            dec_acc = {13'h0, b};
            done    = 1'b1;
        end else if (b[7:5] == 3'b110) begin
            dec_acc     = {16'h0, b[4:0]};
            dec_pending = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            dec_acc     = {17'h0, b[3:0]};
            dec_pending = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            dec_acc     = {18'h0, b[2:0]};
            dec_pending = 2'd3;
        end else begin
            dec_acc = '0;
            u0 = '{16'h0000, 1'b1, 1'b1};
            n  = 1;
        end
        if (done) begin
            if (dec_acc < SUPP_BASE) begin
                u0 = '{dec_acc[15:0], 1'b0, 1'b1};
                n  = 1;
            end else begin
                v  = dec_acc - SUPP_BASE;
                u0 = '{HI_SURR | {5'h0, v[20:10]}, 1'b0, 1'b0};
                u1 = '{LO_SURR | {6'h0, v[9:0]}, 1'b0, 1'b1};
                n  = 2;
            end
        end
    endfunction

    task automatic note_fault(input string what, input t_unit_rec want, input t_unit_rec got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s: expected unit %h err %b last %b, got unit %h err %b last %b",
                     what, want.unit, want.err, want.last, got.unit, got.err, got.last);
        end
    endtask

    task automatic push_req(input logic [7:0] octet, input logic drop);
        t_byte_req r;
        r         = '0;
        r.octet   = octet;
        r.drop    = drop;
        r.bend    = 1'($urandom_range(0, 1));
        byte_reqs = {byte_reqs, r};
    endtask

    function automatic logic [7:0] lead_octet(input int conts);
        logic [7:0] r;
        r = 8'($urandom);
        case (conts)
            1:       return {3'b110, r[4:0]};
            2:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_octet();
        logic [7:0] r;
        r = 8'($urandom);
        return {CONT_TAG, r[5:0]};
    endfunction

    task automatic wait_for_drain(output bit ok);
        int cycles;
        cycles = 0;
        @(negedge i_clk);
        while (decoded_q.size() != 0 && cycles < 20000) begin
            @(negedge i_clk);
            cycles++;
        end
        ok = (decoded_q.size() == 0);
    endtask

    // scoreboard: check each taken unit, predict on each taken request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                mon_got = '{o_unit_out, o_is_error, o_last};
                if (decoded_q.size() == 0) begin
                    note_fault("unexpected unit", '0, mon_got);
                end else begin
                    mon_want = decoded_q.pop_front();
                    if (mon_got !== mon_want) begin
                        note_fault("unit mismatch", mon_want, mon_got);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                decode_octet(i_byte_in, i_drop_partial, mon_u0, mon_u1, mon_n);
                if (byte_reqs[taken_idx].fixed) begin
                    mon_fix   = '{byte_reqs[taken_idx].unit, byte_reqs[taken_idx].err,
                                  byte_reqs[taken_idx].last};
                    decoded_q = {decoded_q, mon_fix};
                end else begin
                    if (mon_n > 0) decoded_q = {decoded_q, mon_u0};
                    if (mon_n > 1) decoded_q = {decoded_q, mon_u1};
                end
                taken_idx++;
            end
        end
    end

    // sink side back-pressure
    initial begin
        int gap;
        int served;
        bit rx_quiet;
        served   = 0;
        rx_quiet = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (served % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            gap = rx_quiet ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid || i_stall) @(posedge i_clk);
            served++;
        end
    end

    // source side: reset, directed table, random streams, drain and verdict
    initial begin
        int         n_dir;
        int         mid;
        int         kind;
        int         len;
        int         gap;
        bit         tx_quiet;
        bit         drop_now;
        bit         ok;
        logic [7:0] bad;
        taken_idx   = 0;
        fault_count = 0;
        dec_acc     = '0;
        dec_pending = '0;
        tx_quiet    = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_byte_in      <= '0;
        i_drop_partial <= 1'b0;
        i_buffer_end   <= 1'b0;

        foreach (dir_table[r]) byte_reqs = {byte_reqs, dir_table[r]};
        n_dir = byte_reqs.size();

        // mostly well-formed sequences, some noise, broken and abandoned ones
        while (byte_reqs.size() < n_dir + 400) begin
            kind     = $urandom_range(0, 15);
            drop_now = ($urandom_range(0, 31) == 0);
            case (kind)
                0, 1, 2, 3: begin
                    bad = 8'($urandom);
                    push_req({1'b0, bad[6:0]}, drop_now);
                end
                4, 5, 6, 7, 8, 9, 10, 11, 12: begin
                    len = (kind < 7) ? 1 : (kind < 10) ? 2 : 3;
                    push_req(lead_octet(len), drop_now);
                    repeat (len) push_req(cont_octet(), 1'b0);
                end
                13: begin
                    push_req(8'($urandom), drop_now);
                end
                14: begin
                    len = $urandom_range(1, 3);
                    push_req(lead_octet(len), drop_now);
                    repeat ($urandom_range(0, len - 1)) push_req(cont_octet(), 1'b0);
                    bad = 8'($urandom);
                    if (bad[7:6] == CONT_TAG) bad[6] = 1'b1;
                    push_req(bad, 1'b0);
                end
                default: begin
                    len = $urandom_range(1, 3);
                    push_req(lead_octet(len), drop_now);
                    repeat ($urandom_range(0, len - 1)) push_req(cont_octet(), 1'b0);
                    push_req(8'($urandom), 1'b1);
                end
            endcase
        end
        mid = n_dir + (byte_reqs.size() - n_dir) / 2;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < byte_reqs.size(); k++) begin
            if (k == n_dir || k == mid) begin
                // hold off until the decoder has emptied
                i_valid <= 1'b0;
                wait_for_drain(ok);
                if (!ok) note_fault("units still queued", decoded_q[0], '0);
                @(posedge i_clk);
            end
            if (k % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
            gap = tx_quiet ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid        <= 1'b1;
            i_byte_in      <= byte_reqs[k].octet;
            i_drop_partial <= byte_reqs[k].drop;
            i_buffer_end   <= byte_reqs[k].bend;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 1'b0;

        wait_for_drain(ok);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (decoded_q.size() != 0) begin
            note_fault("missing unit", decoded_q[0], '0);
        end
        if (fault_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
